### rtl/bht_pkg.sv
// Package for the beacon host table: constants, codes, the slot record
// layout and the beacon name cleaning function. Depends on nothing.
package bht_pkg;

  localparam int unsigned MaxHostsDef = 16;
  localparam logic [15:0] BeaconMagic = 16'h5042;
  localparam logic [7:0]  BeaconVer   = 8'd1;
  localparam logic [5:0]  BeaconBytes = 6'd38;
  localparam logic [31:0] LoopbackIp  = 32'h7F00_0001;

  localparam logic [1:0] REQ_BEACON = 2'd0;
  localparam logic [1:0] REQ_EXPIRE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_REFRESH  = 3'd1;
  localparam logic [2:0] ST_UPGRADE  = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_EXPIRED  = 3'd5;
  localparam logic [2:0] ST_READ     = 3'd6;

  typedef struct packed {
    logic [255:0] name;
    logic [31:0]  ip;
    logic [15:0]  port;
    logic [31:0]  seen;
  } rec_t;

  localparam int unsigned RecW = $bits(rec_t);

  // Clears every byte from the first zero byte on; byte 31 is always cleared.
  function automatic logic [255:0] clean_name(input logic [255:0] raw);
    logic [255:0] res;
    logic         ended;
    res   = '0;
    ended = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (i == 31 || raw[8*i +: 8] == 8'd0) begin
        ended = 1'b1;
      end
      if (!ended) begin
        res[8*i +: 8] = raw[8*i +: 8];
      end
    end
    return res;
  endfunction

endpackage

### rtl/bht_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module bht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/beacon_host_table_with_aging.sv
// Beacon host table with aging: top level. Uses bht_pkg for codes and the
// record layout and bht_ram for the slot record memory.

// A transfer starts when start_i is high while busy_o is low; every item
// gives exactly one result, shown for one cycle with done_o high, and the
// receiver cannot stall it. A rejected beacon, an unknown request or a read
// of a free slot answers in the cycle after it is accepted. A read of a valid
// slot passes through one memory read and the S_RDWAIT state. Beacons and
// expire checks scan the slot memory one slot per cycle via the registered
// read; an expire check visits every slot, a beacon all of them or fewer when
// a matching slot is found early. Slot contents live in one synchronous RAM;
// the valid bits are flip-flops cleared by reset, so no clearing pass is
// needed. expiry_limit_i is written when expiry_limit_we_i is high and
// should only be changed while the block is idle.
module beacon_host_table_with_aging
  import bht_pkg::*;
#(
  parameter int unsigned MAX_HOSTS = bht_pkg::MaxHostsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        expiry_limit_we_i,
  input  logic [31:0] expiry_limit_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] now_ms_i,
  input  logic [5:0]  pkt_len_i,
  input  logic [15:0] magic_i,
  input  logic [7:0]  version_i,
  input  logic [15:0] game_port_i,
  input  logic [31:0] src_ip_i,
  input  logic [63:0] name_w0_i,
  input  logic [63:0] name_w1_i,
  input  logic [63:0] name_w2_i,
  input  logic [63:0] name_w3_i,
  input  logic [3:0]  slot_sel_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [3:0]  slot_o,
  output logic [4:0]  expired_count_o,
  output logic        entry_valid_o,
  output logic [31:0] host_ip_o,
  output logic [15:0] host_port_o,
  output logic [31:0] last_seen_o,
  output logic [63:0] out_name_w0_o,
  output logic [63:0] out_name_w1_o,
  output logic [63:0] out_name_w2_o,
  output logic [63:0] out_name_w3_o
);

  localparam int unsigned IW = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;
  localparam int unsigned CW = IW + 1;
  localparam int unsigned SW = (IW > 4) ? IW : 4;

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_RDWAIT = 2'd2;

  logic [1:0]     state_q, state_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           chk_q, chk_d;
  logic [IW-1:0]  chk_idx_q, chk_idx_d;
  logic           is_exp_q, is_exp_d;
  logic [31:0]    now_q, now_d;
  logic [15:0]    port_q, port_d;
  logic [31:0]    ip_q, ip_d;
  logic [255:0]   name_q, name_d;
  logic           free_q, free_d;
  logic [IW-1:0]  free_idx_q, free_idx_d;
  logic [4:0]     exp_cnt_q, exp_cnt_d;
  logic [MAX_HOSTS-1:0] valid_q, valid_d;
  logic [3:0]     sel_q, sel_d;
  logic [31:0]    limit_q;

  logic           done_q, done_d;
  logic [2:0]     status_q, status_d;
  logic [3:0]     slot_q, slot_d;
  logic [4:0]     expc_q, expc_d;
  logic           ev_q, ev_d;
  rec_t           orec_q, orec_d;

  // Memory port signals.
  logic           ram_we, ram_re;
  logic [IW-1:0]  ram_waddr, ram_raddr;
  rec_t           ram_wdata, ram_rdata;

  logic           accept;
  logic [SW-1:0]  sel_ext;
  logic [SW-1:0]  chk_ext;
  logic [SW-1:0]  free_ext;
  logic           sel_ok;
  logic           beacon_ok;
  logic           slot_match;
  logic [31:0]    age;

  bht_ram #(
    .Width(RecW),
    .Depth(MAX_HOSTS)
  ) u_rec_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign accept   = start_i && !busy_o;
  assign busy_o   = (state_q != S_IDLE);
  assign sel_ext  = SW'(slot_sel_i);
  // The range check is done at full width so that a table of exactly
  // sixteen slots does not wrap the bound to zero.
  assign sel_ok   = (32'(slot_sel_i) < MAX_HOSTS) && valid_q[sel_ext[IW-1:0]];
  assign chk_ext  = SW'(chk_idx_q);
  assign free_ext = SW'(free_idx_q);
  assign beacon_ok = (pkt_len_i >= BeaconBytes) && (magic_i == BeaconMagic) &&
                     (version_i == BeaconVer);
  assign slot_match = valid_q[chk_idx_q] && (ram_rdata.port == port_q) &&
                      (ram_rdata.name == name_q);
  assign age = now_q - ram_rdata.seen;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    chk_d      = 1'b0;
    chk_idx_d  = chk_idx_q;
    is_exp_d   = is_exp_q;
    now_d      = now_q;
    port_d     = port_q;
    ip_d       = ip_q;
    name_d     = name_q;
    free_d     = free_q;
    free_idx_d = free_idx_q;
    exp_cnt_d  = exp_cnt_q;
    valid_d    = valid_q;
    sel_d      = sel_q;
    done_d     = 1'b0;
    status_d   = status_q;
    slot_d     = slot_q;
    expc_d     = expc_q;
    ev_d       = ev_q;
    orec_d     = orec_q;
    ram_we     = 1'b0;
    ram_waddr  = chk_idx_q;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = cnt_q[IW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          now_d     = now_ms_i;
          port_d    = game_port_i;
          ip_d      = src_ip_i;
          name_d    = clean_name({name_w3_i, name_w2_i, name_w1_i, name_w0_i});
          sel_d     = slot_sel_i;
          cnt_d     = '0;
          free_d    = 1'b0;
          exp_cnt_d = '0;
          is_exp_d  = (req_type_i == REQ_EXPIRE);
          // Default result: a rejection with all other fields zero.
          status_d  = ST_REJECTED;
          slot_d    = '0;
          expc_d    = '0;
          ev_d      = 1'b0;
          orec_d    = '0;
          case (req_type_i)
            REQ_BEACON: begin
              if (beacon_ok) begin
                state_d = S_SCAN;
              end else begin
                done_d = 1'b1;
              end
            end
            REQ_EXPIRE: begin
              state_d = S_SCAN;
            end
            REQ_READ: begin
              if (sel_ok) begin
                ram_re    = 1'b1;
                ram_raddr = sel_ext[IW-1:0];
                state_d   = S_RDWAIT;
              end else begin
                status_d = ST_READ;
                slot_d   = slot_sel_i;
                done_d   = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        // Issue the next slot read while the previous slot is checked.
        if (cnt_q < CW'(MAX_HOSTS)) begin
          ram_re    = 1'b1;
          chk_d     = 1'b1;
          chk_idx_d = cnt_q[IW-1:0];
          cnt_d     = cnt_q + 1'b1;
        end
        if (chk_q) begin
          if (is_exp_q) begin
            if (valid_q[chk_idx_q] && (age > limit_q)) begin
              valid_d[chk_idx_q] = 1'b0;
              if (exp_cnt_q != 5'd31) begin
                exp_cnt_d = exp_cnt_q + 5'd1;
              end
            end
            if (cnt_q == CW'(MAX_HOSTS) && chk_idx_q == IW'(MAX_HOSTS - 1)) begin
              state_d  = S_IDLE;
              done_d   = 1'b1;
              status_d = ST_EXPIRED;
              expc_d   = exp_cnt_d;
              chk_d    = 1'b0;
            end
          end else if (slot_match) begin
            // Refresh in place, upgrading a loopback address when possible.
            ram_we         = 1'b1;
            ram_wdata.seen = now_q;
            status_d       = ST_REFRESH;
            if (ram_rdata.ip == LoopbackIp && ip_q != LoopbackIp) begin
              ram_wdata.ip = ip_q;
              status_d     = ST_UPGRADE;
            end
            slot_d  = chk_ext[3:0];
            done_d  = 1'b1;
            state_d = S_IDLE;
            chk_d   = 1'b0;
          end else begin
            if (!valid_q[chk_idx_q] && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = chk_idx_q;
            end
            if (cnt_q == CW'(MAX_HOSTS) && chk_idx_q == IW'(MAX_HOSTS - 1)) begin
              state_d = S_IDLE;
              done_d  = 1'b1;
              chk_d   = 1'b0;
              if (free_d) begin
                ram_we              = 1'b1;
                ram_waddr           = free_idx_d;
                ram_wdata.name      = name_q;
                ram_wdata.ip        = ip_q;
                ram_wdata.port      = port_q;
                ram_wdata.seen      = now_q;
                valid_d[free_idx_d] = 1'b1;
                status_d            = ST_INSERTED;
                slot_d              = free_ext[3:0];
                if (!free_q) begin
                  slot_d = chk_ext[3:0];
                end
              end else begin
                status_d = ST_FULL;
              end
            end
          end
        end
      end

      S_RDWAIT: begin
        status_d = ST_READ;
        slot_d   = sel_q;
        ev_d     = 1'b1;
        orec_d   = ram_rdata;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      chk_q   <= 1'b0;
      valid_q <= '0;
      done_q  <= 1'b0;
      limit_q <= 32'd3000;
      free_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      chk_q   <= chk_d;
      valid_q <= valid_d;
      done_q  <= done_d;
      free_q  <= free_d;
      if (expiry_limit_we_i) begin
        limit_q <= expiry_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q  <= chk_idx_d;
    is_exp_q   <= is_exp_d;
    now_q      <= now_d;
    port_q     <= port_d;
    ip_q       <= ip_d;
    name_q     <= name_d;
    free_idx_q <= free_idx_d;
    exp_cnt_q  <= exp_cnt_d;
    sel_q      <= sel_d;
    status_q   <= status_d;
    slot_q     <= slot_d;
    expc_q     <= expc_d;
    ev_q       <= ev_d;
    orec_q     <= orec_d;
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign slot_o          = slot_q;
  assign expired_count_o = expc_q;
  assign entry_valid_o   = ev_q;
  assign host_ip_o       = orec_q.ip;
  assign host_port_o     = orec_q.port;
  assign last_seen_o     = orec_q.seen;
  assign out_name_w0_o   = orec_q.name[63:0];
  assign out_name_w1_o   = orec_q.name[127:64];
  assign out_name_w2_o   = orec_q.name[191:128];
  assign out_name_w3_o   = orec_q.name[255:192];

  // A result is only ever presented once the sequencer is back in idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result shown while busy");

  // Every accepted item either keeps the block busy or answers at once.
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_o || done_o)) else $error("item dropped");

  // The scan counter never runs past the table.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (cnt_q <= CW'(MAX_HOSTS))) else $error("scan overrun");

  // A result is never produced without an item in flight the cycle before.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(accept) || $past(busy_o))) else $error("spurious result");

endmodule

### dv/tb.sv
// Testbench for the beacon host table with aging: drives beacon, expire and
// read requests, predicts each result and checks it field by field.
// Depends on bht_pkg and the beacon_host_table_with_aging RTL.
module tb;
  import bht_pkg::*;

  localparam int unsigned NumSlots = 16;
  localparam int unsigned CycleLimit = 400000;

  // One expected or observed result.
  typedef struct {
    logic [2:0]   status;
    logic [3:0]   slot;
    logic [4:0]   expired_count;
    logic         entry_valid;
    logic [31:0]  host_ip;
    logic [15:0]  host_port;
    logic [31:0]  last_seen;
    logic [255:0] name;
  } answer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        expiry_limit_we_i = 1'b0;
  logic [31:0] expiry_limit_i = '0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [1:0]  req_type_i = '0;
  logic [31:0] now_ms_i = '0;
  logic [5:0]  pkt_len_i = '0;
  logic [15:0] magic_i = '0;
  logic [7:0]  version_i = '0;
  logic [15:0] game_port_i = '0;
  logic [31:0] src_ip_i = '0;
  logic [63:0] name_w0_i = '0, name_w1_i = '0, name_w2_i = '0, name_w3_i = '0;
  logic [3:0]  slot_sel_i = '0;
  logic        done_o;
  logic [2:0]  status_o;
  logic [3:0]  slot_o;
  logic [4:0]  expired_count_o;
  logic        entry_valid_o;
  logic [31:0] host_ip_o;
  logic [15:0] host_port_o;
  logic [31:0] last_seen_o;
  logic [63:0] out_name_w0_o, out_name_w1_o, out_name_w2_o, out_name_w3_o;

  beacon_host_table_with_aging DUT (.*);

  always #5 clk_i = ~clk_i;

  // Predictor state: a private copy of the table and of the expiry limit.
  logic         host_valid [NumSlots];
  logic [255:0] host_name [NumSlots];
  logic [31:0]  host_addr [NumSlots];
  logic [15:0]  host_gport [NumSlots];
  logic [31:0]  host_seen [NumSlots];
  logic [31:0]  age_limit;

  answer_t pending_answers[$];
  int      error_count = 0;
  int      item_count = 0;
  int      answer_count = 0;
  int      cycle_count = 0;
  int      idle_pct = 21;
  logic [31:0] clock_ms = 32'd1000;
  // A small pool of names and ports so that random beacons often match.
  logic [255:0] name_pool [8];
  logic [15:0]  port_pool [4];

  // Truncates the name at its first zero byte and always clears byte 31.
  function automatic logic [255:0] trim_name(logic [255:0] raw);
    logic [255:0] res;
    logic         stop;
    res  = '0;
    stop = 1'b0;
    for (int i = 0; i < 32; i++) begin
      if (i == 31 || raw[8*i +: 8] == 8'h00) begin
        stop = 1'b1;
      end
      if (!stop) begin
        res[8*i +: 8] = raw[8*i +: 8];
      end
    end
    return res;
  endfunction

  // Applies one request to the table copy and returns the answer it gives.
  function automatic answer_t apply_request(logic [1:0] req, logic [31:0] now,
                                            logic [5:0] len, logic [15:0] mg,
                                            logic [7:0] ver, logic [15:0] gport,
                                            logic [31:0] ip, logic [255:0] raw,
                                            logic [3:0] sel);
    answer_t      a;
    logic [255:0] nm;
    int           cnt;
    a = '{status: ST_REJECTED, default: '0};
    if (req == REQ_BEACON) begin
      if (len < BeaconBytes || mg != BeaconMagic || ver != BeaconVer) begin
        return a;
      end
      nm = trim_name(raw);
      for (int i = 0; i < NumSlots; i++) begin
        if (host_valid[i] && host_gport[i] == gport && host_name[i] == nm) begin
          host_seen[i] = now;
          a.status = ST_REFRESH;
          if (host_addr[i] == LoopbackIp && ip != LoopbackIp) begin
            host_addr[i] = ip;
            a.status = ST_UPGRADE;
          end
          a.slot = i[3:0];
          return a;
        end
      end
      for (int i = 0; i < NumSlots; i++) begin
        if (!host_valid[i]) begin
          host_valid[i] = 1'b1;
          host_name[i]  = nm;
          host_addr[i]  = ip;
          host_gport[i] = gport;
          host_seen[i]  = now;
          a.status = ST_INSERTED;
          a.slot = i[3:0];
          return a;
        end
      end
      a.status = ST_FULL;
    end else if (req == REQ_EXPIRE) begin
      cnt = 0;
      for (int i = 0; i < NumSlots; i++) begin
        if (host_valid[i] && (now - host_seen[i]) > age_limit) begin
          host_valid[i] = 1'b0;
          cnt++;
        end
      end
      a.status = ST_EXPIRED;
      a.expired_count = (cnt > 31) ? 5'd31 : cnt[4:0];
    end else if (req == REQ_READ) begin
      a.status = ST_READ;
      a.slot = sel;
      if (host_valid[sel]) begin
        a.entry_valid = 1'b1;
        a.host_ip     = host_addr[sel];
        a.host_port   = host_gport[sel];
        a.last_seen   = host_seen[sel];
        a.name        = host_name[sel];
      end
    end
    return a;
  endfunction

  // Waits a random gap, then performs one transfer and queues its answer.
  // Called at a falling edge and returns at a falling edge with start_i
  // still high; the next call or a drain lowers it.
  task automatic send_request(logic [1:0] req, logic [31:0] now, logic [5:0] len,
                              logic [15:0] mg, logic [7:0] ver, logic [15:0] gport,
                              logic [31:0] ip, logic [255:0] raw, logic [3:0] sel);
    answer_t next_ans;
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i     <= 1'b1;
    req_type_i  <= req;
    now_ms_i    <= now;
    pkt_len_i   <= len;
    magic_i     <= mg;
    version_i   <= ver;
    game_port_i <= gport;
    src_ip_i    <= ip;
    {name_w3_i, name_w2_i, name_w1_i, name_w0_i} <= raw;
    slot_sel_i  <= sel;
    // The transfer happens at the first rising edge with busy low.
    do begin
      @(posedge clk_i);
    end while (busy_o);
    next_ans = apply_request(req, now, len, mg, ver, gport, ip, raw, sel);
    pending_answers = {pending_answers, next_ans};
    item_count++;
    @(negedge clk_i);
  endtask

  task automatic send_beacon(logic [31:0] now, logic [15:0] gport, logic [31:0] ip,
                             logic [255:0] raw);
    send_request(REQ_BEACON, now, BeaconBytes, BeaconMagic, BeaconVer, gport, ip,
                 raw, 4'd0);
  endtask

  task automatic send_expire(logic [31:0] now);
    send_request(REQ_EXPIRE, now, $urandom, $urandom, $urandom, $urandom, $urandom,
                 {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom}, $urandom);
  endtask

  task automatic send_read(logic [3:0] sel);
    send_request(REQ_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, {8{$urandom}}, sel);
  endtask

  // Waits until every answer has arrived plus the longest scan, so the
  // block is idle before the expiry limit changes.
  task automatic drain_table();
    start_i <= 1'b0;
    while (pending_answers.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (NumSlots + 4) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [31:0] value);
    drain_table();
    expiry_limit_we_i <= 1'b1;
    expiry_limit_i    <= value;
    @(negedge clk_i);
    expiry_limit_we_i <= 1'b0;
    age_limit = value;
  endtask

  function automatic logic [255:0] random_name();
    logic [255:0] n;
    n = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom};
    // Often plant an early terminator so the truncation is exercised.
    if ($urandom_range(2) == 0) begin
      n[8*$urandom_range(31) +: 8] = 8'h00;
    end
    return n;
  endfunction

  // Checker: every done strobe must match the oldest queued answer.
  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && done_o) begin
      answer_count++;
      if (pending_answers.size() == 0) begin
        $error("result with no outstanding request: status %0d", status_o);
        error_count++;
      end else begin
        e = pending_answers.pop_front();
        if (status_o !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status_o);
          error_count++;
        end
        if (slot_o !== e.slot) begin
          $error("slot: expected %0d, got %0d", e.slot, slot_o);
          error_count++;
        end
        if (expired_count_o !== e.expired_count) begin
          $error("expired_count: expected %0d, got %0d", e.expired_count,
                 expired_count_o);
          error_count++;
        end
        if (entry_valid_o !== e.entry_valid) begin
          $error("entry_valid: expected %0d, got %0d", e.entry_valid, entry_valid_o);
          error_count++;
        end
        if (host_ip_o !== e.host_ip) begin
          $error("host_ip: expected %h, got %h", e.host_ip, host_ip_o);
          error_count++;
        end
        if (host_port_o !== e.host_port) begin
          $error("host_port: expected %h, got %h", e.host_port, host_port_o);
          error_count++;
        end
        if (last_seen_o !== e.last_seen) begin
          $error("last_seen: expected %h, got %h", e.last_seen, last_seen_o);
          error_count++;
        end
        if (out_name_w0_o !== e.name[63:0]) begin
          $error("out_name_w0: expected %h, got %h", e.name[63:0], out_name_w0_o);
          error_count++;
        end
        if (out_name_w1_o !== e.name[127:64]) begin
          $error("out_name_w1: expected %h, got %h", e.name[127:64], out_name_w1_o);
          error_count++;
        end
        if (out_name_w2_o !== e.name[191:128]) begin
          $error("out_name_w2: expected %h, got %h", e.name[191:128], out_name_w2_o);
          error_count++;
        end
        if (out_name_w3_o !== e.name[255:192]) begin
          $error("out_name_w3: expected %h, got %h", e.name[255:192], out_name_w3_o);
          error_count++;
        end
      end
    end
  end

  // Watchdog: the slowest run is far below this bound.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Directed checks of rejection: every malformed header and unknown request.
  task automatic test_rejects();
    send_request(REQ_BEACON, clock_ms, 6'd37, BeaconMagic, BeaconVer, 16'h1, 32'h1,
                 {32{8'h41}}, 4'd0);
    send_request(REQ_BEACON, clock_ms, 6'd0, BeaconMagic, BeaconVer, 16'h1, 32'h1,
                 {32{8'h41}}, 4'd0);
    send_request(REQ_BEACON, clock_ms, BeaconBytes, 16'h5043, BeaconVer, 16'h1, 32'h1,
                 {32{8'h41}}, 4'd0);
    send_request(REQ_BEACON, clock_ms, BeaconBytes, BeaconMagic, 8'd2, 16'h1, 32'h1,
                 {32{8'h41}}, 4'd0);
    send_request(2'd3, 32'hFFFF_FFFF, 6'h3F, 16'hFFFF, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF,
                 {256{1'b1}}, 4'hF);
  endtask

  // Directed checks of insert, refresh, loopback upgrade, full table and reads.
  task automatic test_learning();
    // An overlong beacon counts as a full one; the name keeps bytes 0..30.
    send_request(REQ_BEACON, clock_ms, 6'h3F, BeaconMagic, BeaconVer, 16'hFFFF,
                 LoopbackIp, {256{1'b1}}, 4'd0);
    send_beacon(clock_ms + 5, 16'hFFFF, LoopbackIp, {256{1'b1}});
    send_beacon(clock_ms + 6, 16'hFFFF, 32'hC0A8_0001, {256{1'b1}});
    send_beacon(clock_ms, 16'h0000, 32'h0, '0);
    send_read(4'd0);
    send_read(4'd1);
    for (int i = 2; i < NumSlots + 1; i++) begin
      send_beacon(clock_ms, i[15:0], 32'h0A00_0000 + i, random_name());
    end
    send_read(4'd15);
  endtask

  // Expiry against the reset limit, including a wrapped time stamp.
  task automatic test_aging();
    send_expire(clock_ms + 3000);
    send_expire(clock_ms + 3001);
    send_read(4'd15);
    send_beacon(32'hFFFF_FFF0, 16'h77, 32'h1, {248'h0, 8'h42});
    send_expire(32'h0000_0010);
    send_expire(32'h0000_0BC0);
  endtask

  // Random traffic: mostly good beacons from a small pool, plus expiry and
  // reads, with some broken headers; the limit is changed between phases.
  task automatic test_random_traffic(int count, logic [31:0] limit);
    int           pick;
    logic [255:0] nm;
    write_limit(limit);
    for (int k = 0; k < count; k++) begin
      clock_ms += $urandom_range(400);
      pick = $urandom_range(99);
      if (pick < 55) begin
        nm = ($urandom_range(3) == 0) ? random_name() : name_pool[$urandom_range(7)];
        send_beacon(clock_ms, port_pool[$urandom_range(3)],
                    ($urandom_range(2) == 0) ? LoopbackIp : $urandom, nm);
      end else if (pick < 65) begin
        send_request(REQ_BEACON, clock_ms, $urandom_range(63),
                     ($urandom_range(1) != 0) ? BeaconMagic : $urandom,
                     ($urandom_range(1) != 0) ? BeaconVer : $urandom, $urandom,
                     $urandom, random_name(), $urandom);
      end else if (pick < 77) begin
        send_expire(($urandom_range(9) == 0) ? $urandom : clock_ms);
      end else if (pick < 97) begin
        send_read($urandom);
      end else begin
        send_request(2'd3, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     random_name(), $urandom);
      end
      // Once per phase, hold off until the block has answered everything.
      if (k == count / 2) begin
        start_i <= 1'b0;
        while (pending_answers.size() != 0) @(negedge clk_i);
      end
    end
  endtask

  initial begin
    age_limit = 32'd3000;
    for (int i = 0; i < NumSlots; i++) begin
      host_valid[i] = 1'b0;
    end
    for (int i = 0; i < 8; i++) begin
      name_pool[i] = random_name();
    end
    for (int i = 0; i < 4; i++) begin
      port_pool[i] = $urandom;
    end
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_rejects();
    test_learning();
    test_aging();

    test_random_traffic(300, 32'd0);
    test_random_traffic(300, 32'hFFFF_FFFF);
    // A stretch with no idle cycles on the sender side.
    idle_pct = 0;
    test_random_traffic(300, 32'd2500);
    idle_pct = 21;
    test_random_traffic(325, 32'd800);
    test_random_traffic(300, 32'd6000);

    drain_table();
    $display("tb: %0d requests sent, %0d answers checked; beacons, aging at", item_count,
             answer_count);
    $display("tb: limits 0 to 2^32-1, reads and malformed requests were covered");
    if (error_count == 0 && pending_answers.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
